// ----- src/mwce_pkg.sv -----
// Package for the multi-width constant evaluator.
// Holds codes, pipeline types and width helper functions; depends on nothing.
package mwce_pkg;

    typedef enum logic [1:0] {
        ACT_REFUSE = 2'd0,
        ACT_CONST  = 2'd1,
        ACT_JUMP   = 2'd2,
        ACT_DELETE = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        KIND_FIXED = 2'd0,
        KIND_MUL   = 2'd1,
        KIND_DIV   = 2'd2
    } kind_t;

    localparam logic [4:0] F_NOT   = 5'd0;
    localparam logic [4:0] F_NEG   = 5'd1;
    localparam logic [4:0] F_LNOT  = 5'd2;
    localparam logic [4:0] F_PLUS  = 5'd3;
    localparam logic [4:0] F_ADD   = 5'd4;
    localparam logic [4:0] F_SUB   = 5'd5;
    localparam logic [4:0] F_MUL   = 5'd6;
    localparam logic [4:0] F_SDIV  = 5'd7;
    localparam logic [4:0] F_SMOD  = 5'd8;
    localparam logic [4:0] F_UDIV  = 5'd9;
    localparam logic [4:0] F_UMOD  = 5'd10;
    localparam logic [4:0] F_AND   = 5'd11;
    localparam logic [4:0] F_OR    = 5'd12;
    localparam logic [4:0] F_XOR   = 5'd13;
    localparam logic [4:0] F_SHL   = 5'd14;
    localparam logic [4:0] F_SHR   = 5'd15;
    localparam logic [4:0] F_SAR   = 5'd16;
    localparam logic [4:0] F_CMP   = 5'd17;
    localparam logic [4:0] F_TRUNC = 5'd18;
    localparam logic [4:0] F_SEXT  = 5'd19;

    localparam logic [3:0] C_EQ = 4'd0;
    localparam logic [3:0] C_NE = 4'd1;
    localparam logic [3:0] C_GT = 4'd2;
    localparam logic [3:0] C_GE = 4'd3;
    localparam logic [3:0] C_LT = 4'd4;
    localparam logic [3:0] C_LE = 4'd5;
    localparam logic [3:0] C_A  = 4'd6;
    localparam logic [3:0] C_AE = 4'd7;
    localparam logic [3:0] C_B  = 4'd8;
    localparam logic [3:0] C_BE = 4'd9;

    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic        valid;
        act_t        action;
        kind_t       kind;
        logic        ds;
        logic [3:0]  db;
        logic        sdiv;
        logic        qneg;
        logic        rneg;
        logic        want_rem;
        logic [63:0] res;
    } pipe_t;

    function automatic logic [63:0] mask_of(logic [3:0] bytes);
        logic [63:0] m;
        case (bytes)
            4'd1: m = 64'h0000_0000_0000_00FF;
            4'd2: m = 64'h0000_0000_0000_FFFF;
            4'd3: m = 64'h0000_0000_00FF_FFFF;
            4'd4: m = 64'h0000_0000_FFFF_FFFF;
            4'd5: m = 64'h0000_00FF_FFFF_FFFF;
            4'd6: m = 64'h0000_FFFF_FFFF_FFFF;
            4'd7: m = 64'h00FF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] top_bit(logic [3:0] bytes);
        return {bytes[2:0], 3'b000} - 6'd1;
    endfunction

    function automatic logic [63:0] sext_of(logic [63:0] v, logic [3:0] bytes);
        logic [63:0] m;
        m = mask_of(bytes);
        return v[top_bit(bytes)] ? (v | ~m) : (v & m);
    endfunction

    function automatic logic [63:0] norm(logic [63:0] v, logic [3:0] bytes, logic sgn);
        return sgn ? sext_of(v, bytes) : (v & mask_of(bytes));
    endfunction

endpackage

// ----- src/mwce_front.sv -----
// Decode stage: normalizes operands, checks refusals and computes all simple results.
// Depends on mwce_pkg.
module mwce_front
    import mwce_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [4:0]  func,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [3:0]  a_bytes,
    input  logic        a_signed,
    input  logic [3:0]  b_bytes,
    input  logic        b_signed,
    input  logic [3:0]  dst_bytes,
    input  logic        dst_signed,
    input  logic [3:0]  condition,
    output pipe_t       ctl,
    output logic [63:0] ul,
    output logic [63:0] ur,
    output logic [63:0] sa,
    output logic [63:0] sb
);

    pipe_t       ctl_reg, ctl_next;
    logic [63:0] ul_reg, ur_reg, sa_reg, sb_reg;
    logic [63:0] ul_c, ur_c, sa_c, sb_c;

    function automatic logic wok(logic [3:0] bytes);
        return (bytes >= 4'd1) && ({28'd0, bytes} <= MAX_BYTES) && (bytes <= 4'd8);
    endfunction

    always_comb begin
        logic        dok;
        logic [63:0] m, sh, t, minv, l, r;
        logic [5:0]  shv;
        logic        taken, cok;
        dok = wok(dst_bytes);
        m = mask_of(dst_bytes);
        ul_c = norm(operand_a, dst_bytes, dst_signed);
        ur_c = norm(operand_b, dst_bytes, dst_signed);
        sa_c = sext_of(operand_a, dst_bytes);
        sb_c = sext_of(operand_b, dst_bytes);
        minv = ~(m >> 1);
        sh = norm(operand_b, b_bytes, b_signed);
        shv = sh[5:0];
        t = operand_a & m;
        l = operand_a & mask_of(a_bytes);
        r = operand_b & mask_of(a_bytes);
        taken = 1'b0;
        cok = 1'b1;
        ctl_next = '0;
        ctl_next.valid = in_valid;
        ctl_next.action = ACT_REFUSE;
        ctl_next.kind = KIND_FIXED;
        ctl_next.ds = dst_signed;
        ctl_next.db = dst_bytes;
        case (func)
            F_NOT, F_NEG, F_PLUS: begin
                if (dok) begin
                    ctl_next.action = ACT_CONST;
                    ctl_next.res = (func == F_NOT) ? ~operand_a :
                                   (func == F_NEG) ? 64'd0 - operand_a : operand_a;
                end
            end
            F_LNOT: begin
                if (dok && wok(a_bytes)) begin
                    ctl_next.action = ACT_CONST;
                    ctl_next.res = {63'd0, norm(operand_a, a_bytes, a_signed) == 64'd0};
                end
            end
            F_ADD, F_SUB, F_AND, F_OR, F_XOR: begin
                if (dok) begin
                    ctl_next.action = ACT_CONST;
                    case (func)
                        F_ADD:   ctl_next.res = ul_c + ur_c;
                        F_SUB:   ctl_next.res = ul_c - ur_c;
                        F_AND:   ctl_next.res = ul_c & ur_c;
                        F_OR:    ctl_next.res = ul_c | ur_c;
                        default: ctl_next.res = ul_c ^ ur_c;
                    endcase
                end
            end
            F_MUL: begin
                if (dok) begin
                    ctl_next.action = ACT_CONST;
                    ctl_next.kind = KIND_MUL;
                end
            end
            F_SDIV, F_SMOD: begin
                if (dok && sb_c != 64'd0 && !(sa_c == minv && sb_c == '1)) begin
                    ctl_next.action = ACT_CONST;
                    ctl_next.kind = KIND_DIV;
                    ctl_next.sdiv = 1'b1;
                    ctl_next.qneg = sa_c[63] ^ sb_c[63];
                    ctl_next.rneg = sa_c[63];
                    ctl_next.want_rem = (func == F_SMOD);
                end
            end
            F_UDIV, F_UMOD: begin
                if (dok && ur_c != 64'd0) begin
                    ctl_next.action = ACT_CONST;
                    ctl_next.kind = KIND_DIV;
                    ctl_next.want_rem = (func == F_UMOD);
                end
            end
            F_SHL, F_SHR, F_SAR: begin
                if (dok && wok(b_bytes) && !(b_signed && sh[63])
                        && sh < {57'd0, dst_bytes, 3'b000}) begin
                    ctl_next.action = ACT_CONST;
                    case (func)
                        F_SHL: ctl_next.res = ul_c << shv;
                        F_SHR: ctl_next.res = ul_c >> shv;
                        default: begin
                            ctl_next.res = t >> shv;
                            if (shv != 6'd0 && t[top_bit(dst_bytes)])
                                ctl_next.res = ctl_next.res | (m ^ (m >> shv));
                        end
                    endcase
                end
            end
            F_CMP: begin
                case (condition)
                    C_EQ: taken = l == r;
                    C_NE: taken = l != r;
                    C_GT: taken = $signed(sext_of(operand_a, a_bytes)) >
                                  $signed(sext_of(operand_b, a_bytes));
                    C_GE: taken = $signed(sext_of(operand_a, a_bytes)) >=
                                  $signed(sext_of(operand_b, a_bytes));
                    C_LT: taken = $signed(sext_of(operand_a, a_bytes)) <
                                  $signed(sext_of(operand_b, a_bytes));
                    C_LE: taken = $signed(sext_of(operand_a, a_bytes)) <=
                                  $signed(sext_of(operand_b, a_bytes));
                    C_A:  taken = l > r;
                    C_AE: taken = l >= r;
                    C_B:  taken = l < r;
                    C_BE: taken = l <= r;
                    default: cok = 1'b0;
                endcase
                if (wok(a_bytes) && wok(b_bytes) && a_bytes == b_bytes && cok)
                    ctl_next.action = taken ? ACT_JUMP : ACT_DELETE;
            end
            F_TRUNC: begin
                if (dok) begin
                    ctl_next.action = ACT_CONST;
                    ctl_next.res = operand_a & m;
                end
            end
            F_SEXT: begin
                if (dok && a_bytes >= 4'd1 && dst_bytes > a_bytes) begin
                    ctl_next.action = ACT_CONST;
                    ctl_next.res = sext_of(operand_a, a_bytes);
                end
            end
            default: ctl_next.action = ACT_REFUSE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ul_reg <= ul_c;
            ur_reg <= ur_c;
            sa_reg <= sa_c;
            sb_reg <= sb_c;
        end
    end

    assign ctl = ctl_reg;
    assign ul  = ul_reg;
    assign ur  = ur_reg;
    assign sa  = sa_reg;
    assign sb  = sb_reg;

endmodule

// ----- src/mwce_prep.sv -----
// Two stages: 32-bit partial products and divider operand magnitudes, then the product sum.
// Depends on mwce_pkg.
module mwce_prep
    import mwce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  pipe_t       ctl_in,
    input  logic [63:0] ul,
    input  logic [63:0] ur,
    input  logic [63:0] sa,
    input  logic [63:0] sb,
    output pipe_t       ctl_out,
    output logic [63:0] dividend,
    output logic [63:0] divisor
);

    pipe_t       p_ctl_reg, m_ctl_reg, m_ctl_next;
    logic [63:0] pp0_reg;
    logic [31:0] pp1_reg, pp2_reg;
    logic [63:0] p_dvd_reg, p_dvs_reg, m_dvd_reg, m_dvs_reg;
    logic [63:0] dvd_c, dvs_c;
    logic [31:0] p1_full, p2_full;

    always_comb begin
        if (ctl_in.sdiv) begin
            dvd_c = sa[63] ? 64'd0 - sa : sa;
            dvs_c = sb[63] ? 64'd0 - sb : sb;
        end else begin
            dvd_c = ul;
            dvs_c = ur;
        end
        p1_full = ul[31:0] * ur[63:32];
        p2_full = ul[63:32] * ur[31:0];
    end

    always_comb begin
        m_ctl_next = p_ctl_reg;
        if (p_ctl_reg.kind == KIND_MUL)
            m_ctl_next.res = pp0_reg + {pp1_reg + pp2_reg, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctl_reg <= '0;
            m_ctl_reg <= '0;
        end else if (en) begin
            p_ctl_reg <= ctl_in;
            m_ctl_reg <= m_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp0_reg   <= ul[31:0] * ur[31:0];
            pp1_reg   <= p1_full;
            pp2_reg   <= p2_full;
            p_dvd_reg <= dvd_c;
            p_dvs_reg <= dvs_c;
            m_dvd_reg <= p_dvd_reg;
            m_dvs_reg <= p_dvs_reg;
        end
    end

    assign ctl_out  = m_ctl_reg;
    assign dividend = m_dvd_reg;
    assign divisor  = m_dvs_reg;

endmodule

// ----- src/mwce_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with the item's control riding along.
// Depends on mwce_pkg.
module mwce_div
    import mwce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  pipe_t       ctl_in,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output pipe_t       ctl_out,
    output logic [63:0] quot,
    output logic [63:0] rem
);

    pipe_t       ctl_reg [DIV_STEPS];
    logic [63:0] q_reg [DIV_STEPS];
    logic [63:0] r_reg [DIV_STEPS];
    logic [63:0] d_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            pipe_t       c_in;
            logic [63:0] q_in, r_in, d_in, q_nx, r_nx;
            logic [64:0] t, diff;
            if (k == 0) begin : g_first
                assign c_in = ctl_in;
                assign q_in = dividend;
                assign r_in = 64'd0;
                assign d_in = divisor;
            end else begin : g_rest
                assign c_in = ctl_reg[k-1];
                assign q_in = q_reg[k-1];
                assign r_in = r_reg[k-1];
                assign d_in = d_reg[k-1];
            end
            always_comb begin
                t = {r_in, q_in[63]};
                diff = t - {1'b0, d_in};
                if (!diff[64]) begin
                    r_nx = diff[63:0];
                    q_nx = {q_in[62:0], 1'b1};
                end else begin
                    r_nx = t[63:0];
                    q_nx = {q_in[62:0], 1'b0};
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    ctl_reg[k] <= '0;
                end else if (en) begin
                    ctl_reg[k] <= c_in;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[k] <= q_nx;
                    r_reg[k] <= r_nx;
                    d_reg[k] <= d_in;
                end
            end
        end
    endgenerate

    assign ctl_out = ctl_reg[DIV_STEPS-1];
    assign quot    = q_reg[DIV_STEPS-1];
    assign rem     = r_reg[DIV_STEPS-1];

endmodule

// ----- src/mwce_back.sv -----
// Result stage: applies division signs, normalizes to the destination type, holds the output.
// Depends on mwce_pkg.
module mwce_back
    import mwce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pipe_t       ctl_in,
    input  logic [63:0] quot,
    input  logic [63:0] rem,
    input  logic        out_ready,
    output logic        en,
    output logic        out_valid,
    output logic [1:0]  out_action,
    output logic [63:0] out_value
);

    logic        valid_reg;
    logic [1:0]  action_reg;
    logic [63:0] value_reg;
    logic [63:0] res_c, value_c;

    assign en = !valid_reg || out_ready;

    always_comb begin
        if (ctl_in.kind == KIND_DIV) begin
            if (ctl_in.want_rem)
                res_c = ctl_in.rneg ? 64'd0 - rem : rem;
            else
                res_c = ctl_in.qneg ? 64'd0 - quot : quot;
        end else begin
            res_c = ctl_in.res;
        end
        value_c = (ctl_in.action == ACT_CONST) ? norm(res_c, ctl_in.db, ctl_in.ds) : 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            action_reg <= ctl_in.action;
            value_reg  <= value_c;
        end
    end

    assign out_valid  = valid_reg;
    assign out_action = action_reg;
    assign out_value  = value_reg;

endmodule

// ----- src/multi_width_constant_evaluator_core.sv -----
// Multi-width constant evaluator top level: decode, multiply prep, divider, result stage.
// One item is accepted every cycle while the output register is empty or being taken.
// The depth is set by the 64-stage divider that every item passes through.
// The whole pipeline holds when the output register is full and not taken.
// Synchronous active-low reset clears all valid bits; no clearing pass is needed.
module multi_width_constant_evaluator_core
    import mwce_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[4:0], operand_a[68:5], operand_b[132:69], a_bytes[136:133], a_signed[137],
    // b_bytes[141:138], b_signed[142], dst_bytes[146:143], dst_signed[147],
    // condition[151:148]
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // action[1:0], value[65:2], zero fill [71:66]
    output logic [71:0]  m_tdata
);

    logic        en;
    pipe_t       f_ctl, p_ctl, d_ctl;
    logic [63:0] ul, ur, sa, sb, dvd, dvs, quot, rem;
    logic [1:0]  out_action;
    logic [63:0] out_value;

    assign s_tready = en;

    mwce_front #(.MAX_BYTES(MAX_BYTES)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .func       (s_tdata[4:0]),
        .operand_a  (s_tdata[68:5]),
        .operand_b  (s_tdata[132:69]),
        .a_bytes    (s_tdata[136:133]),
        .a_signed   (s_tdata[137]),
        .b_bytes    (s_tdata[141:138]),
        .b_signed   (s_tdata[142]),
        .dst_bytes  (s_tdata[146:143]),
        .dst_signed (s_tdata[147]),
        .condition  (s_tdata[151:148]),
        .ctl        (f_ctl),
        .ul         (ul),
        .ur         (ur),
        .sa         (sa),
        .sb         (sb)
    );

    mwce_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctl_in   (f_ctl),
        .ul       (ul),
        .ur       (ur),
        .sa       (sa),
        .sb       (sb),
        .ctl_out  (p_ctl),
        .dividend (dvd),
        .divisor  (dvs)
    );

    mwce_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctl_in   (p_ctl),
        .dividend (dvd),
        .divisor  (dvs),
        .ctl_out  (d_ctl),
        .quot     (quot),
        .rem      (rem)
    );

    mwce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl_in     (d_ctl),
        .quot       (quot),
        .rem        (rem),
        .out_ready  (m_tready),
        .en         (en),
        .out_valid  (m_tvalid),
        .out_action (out_action),
        .out_value  (out_value)
    );

    assign m_tdata = {6'd0, out_value, out_action};

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register state");

    a_nonconst_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != ACT_CONST) |-> m_tdata[65:2] == 64'd0)
        else $error("non-constant result carries a value");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
